@@ sv/bzl_pkg.sv @@
// ----------------------------------------------------------------------------
// bzl_pkg: shared definitions for the cubic Bezier length engine
// Widths, defaults, sequencer states and the multiply-accumulate control word.
// ----------------------------------------------------------------------------
`default_nettype none
package bzl_pkg;

	localparam int COORD_W = 32;
	localparam int T_W     = 30;
	localparam int LEN_W   = 40;
	localparam int PREC_W  = 32;
	localparam int OPD_W   = 33;
	localparam int PROD_W  = 66;
	localparam int ACC_W   = 68;
	localparam int ROOT_W  = 34;
	localparam int WORD_SEL_W = 4;

	localparam int STACK_DEPTH_DEF    = 32;
	localparam int T_FULL_SPAN_DEF    = 1073741823;
	localparam int MIN_SPAN_SHIFT_DEF = 10;

	localparam logic [PREC_W-1:0] PRECISION_RESET = 32'd65536;

	// stack entry layout: word = {point, axis}; axis slot 3 holds the t-span
	localparam logic [WORD_SEL_W-1:0] WORD_TMIN = 4'd3;
	localparam logic [WORD_SEL_W-1:0] WORD_TMAX = 4'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COL,
		ST_TEST,
		ST_SPLIT,
		ST_CHORD,
		ST_SQRT,
		ST_POP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic sub;
	} mac_ctl_t;

endpackage
`default_nettype wire

@@ sv/bzl_mac.sv @@
// ----------------------------------------------------------------------------
// bzl_mac: shared multiply-accumulate unit
// One signed 33x33 product per cycle, registered, then loaded into, added
// into or subtracted from a 68-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module bzl_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bzl_pkg::mac_ctl_t                  ctl,
	input  logic signed [bzl_pkg::OPD_W-1:0]   opa,
	input  logic signed [bzl_pkg::OPD_W-1:0]   opb,
	output logic signed [bzl_pkg::ACC_W-1:0]   acc
);
	import bzl_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	assign prod_ext = ACC_W'(prod_s1);
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			if (ctl_s1.first) begin
				acc_q <= prod_ext;
			end else if (ctl_s1.sub) begin
				acc_q <= acc_q - prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/bzl_sqrt.sv @@
// ----------------------------------------------------------------------------
// bzl_sqrt: iterative floor square root
// Restoring method, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bzl_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [bzl_pkg::ACC_W-1:0]    radicand,
	output logic                         done,
	output logic [bzl_pkg::ROOT_W-1:0]   root
);
	import bzl_pkg::*;

	localparam int REM_W  = ROOT_W + 3;
	localparam int ITER_W = $clog2(ROOT_W + 1);

	logic [ACC_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ITER_W-1:0] iter_q;
	logic              run_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[ACC_W-1:ACC_W-2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				iter_q <= ITER_W'(ROOT_W);
			end else if (run_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

@@ sv/bzl_stack.sv @@
// ----------------------------------------------------------------------------
// bzl_stack: pending-piece memory
// Sixteen words per entry: twelve coordinates and the t-span of the piece.
// ----------------------------------------------------------------------------
`default_nettype none
module bzl_stack #(
	parameter int DEPTH = bzl_pkg::STACK_DEPTH_DEF
) (
	input  logic                                              clk,
	input  logic                                              we,
	input  logic [$clog2(DEPTH)+bzl_pkg::WORD_SEL_W-1:0]      waddr,
	input  logic [bzl_pkg::COORD_W-1:0]                       wdata,
	input  logic [$clog2(DEPTH)+bzl_pkg::WORD_SEL_W-1:0]      raddr,
	output logic [bzl_pkg::COORD_W-1:0]                       rdata
);
	import bzl_pkg::*;

	localparam int WORDS = DEPTH * (2 ** WORD_SEL_W);

	logic [COORD_W-1:0] mem [WORDS];
	logic [COORD_W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/cubic_bezier_arc_length.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_arc_length: length of a 3D cubic Bezier by adaptive halving
// Collinear shortcut, then depth-first de Casteljau split with chord sums.
// ----------------------------------------------------------------------------
// Usage
//   Raise start with the twelve Q16.16 coordinates while busy is low; the
//   transaction is taken at that edge and busy rises on the next cycle.
//   The result (arc_length, was_straight) is shown for exactly one cycle
//   with done high; busy falls the cycle after. The receiver cannot stall.
//   precision is written through cfg_wen/cfg_wdata; the user must do so only
//   while the block is idle, as the block itself does not enforce it.
// Steps
//   Collinearity test: one determinant per plane and control point, stopping
//   at the first that fails. Each chord: the squared axis differences are
//   summed through the shared multiplier, then square-rooted at one root
//   bit a cycle. Each split: up to six flatness tests plus 14 stack writes
//   (one memory port). Each pop: 16 stack reads.
//   Curves are handled one at a time.
// Reset
//   Clears the sequencer and stack level and loads precision with 1.0.
//   The stack memory needs no clearing: an entry is always written before
//   it is read within one curve.
// ----------------------------------------------------------------------------
`default_nettype none
module cubic_bezier_arc_length #(
	parameter int STACK_DEPTH    = bzl_pkg::STACK_DEPTH_DEF,
	parameter int T_FULL_SPAN    = bzl_pkg::T_FULL_SPAN_DEF,
	parameter int MIN_SPAN_SHIFT = bzl_pkg::MIN_SPAN_SHIFT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                cfg_wen,
	input  logic [bzl_pkg::PREC_W-1:0]          cfg_wdata,
	input  logic signed [bzl_pkg::COORD_W-1:0]  start_x,
	input  logic signed [bzl_pkg::COORD_W-1:0]  start_y,
	input  logic signed [bzl_pkg::COORD_W-1:0]  start_z,
	input  logic signed [bzl_pkg::COORD_W-1:0]  ctrl1_x,
	input  logic signed [bzl_pkg::COORD_W-1:0]  ctrl1_y,
	input  logic signed [bzl_pkg::COORD_W-1:0]  ctrl1_z,
	input  logic signed [bzl_pkg::COORD_W-1:0]  ctrl2_x,
	input  logic signed [bzl_pkg::COORD_W-1:0]  ctrl2_y,
	input  logic signed [bzl_pkg::COORD_W-1:0]  ctrl2_z,
	input  logic signed [bzl_pkg::COORD_W-1:0]  end_x,
	input  logic signed [bzl_pkg::COORD_W-1:0]  end_y,
	input  logic signed [bzl_pkg::COORD_W-1:0]  end_z,
	output logic [bzl_pkg::LEN_W-1:0]           arc_length,
	output logic                                was_straight
);
	import bzl_pkg::*;

	localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
	localparam int LVL_IW = $clog2(STACK_DEPTH);
	localparam int AW     = LVL_IW + WORD_SEL_W;
	localparam int PT_W   = 3 * COORD_W;
	localparam int FL_W   = 36;

	// pick one axis of a packed point
	function automatic logic signed [COORD_W-1:0] ax_of(input logic [PT_W-1:0] v,
	                                                   input logic [1:0] ax);
		case (ax)
			2'd0:    ax_of = v[COORD_W-1:0];
			2'd1:    ax_of = v[2*COORD_W-1:COORD_W];
			default: ax_of = v[3*COORD_W-1:2*COORD_W];
		endcase
	endfunction

	// floor((a+b)/2)
	function automatic logic signed [COORD_W-1:0] mid(input logic signed [COORD_W-1:0] a,
	                                                 input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] sum;
		sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		mid = sum[COORD_W:1];
	endfunction

	function automatic logic signed [OPD_W-1:0] diff(input logic signed [COORD_W-1:0] a,
	                                                input logic signed [COORD_W-1:0] b);
		diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	function automatic logic signed [FL_W-1:0] ext(input logic signed [COORD_W-1:0] a);
		ext = FL_W'(a);
	endfunction

	function automatic logic [LEN_W-1:0] add_sat(input logic [LEN_W-1:0] a,
	                                            input logic [ROOT_W-1:0] b);
		logic [LEN_W:0] sum;
		sum = {1'b0, a} + (LEN_W+1)'(b);
		add_sat = sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [PT_W-1:0]   s_q, c1_q, c2_q, e_q;
	logic [T_W-1:0]    tmin_q, tmax_q;
	logic [LVL_W-1:0]  level_q;
	logic [3:0]        cnt_q;
	logic [2:0]        didx_q;
	logic              straight_q;
	logic [LEN_W-1:0]  len_q;
	logic [PREC_W-1:0] prec_q;

	// shared unit hookup
	mac_ctl_t                mac_ctl;
	logic signed [OPD_W-1:0] opa, opb;
	logic signed [ACC_W-1:0] acc;
	logic                    sq_go, sq_done;
	logic [ROOT_W-1:0]       root;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [COORD_W-1:0] mem_wdata, mem_rdata;

	bzl_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.opa    (opa),
		.opb    (opb),
		.acc    (acc)
	);

	bzl_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go),
		.radicand (acc),
		.done     (sq_done),
		.root     (root)
	);

	bzl_stack #(.DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// collinearity plane and control point for the current determinant
	logic [1:0] pl_u, pl_v;
	logic       pl_c2;
	always_comb begin
		pl_c2 = (didx_q >= 3'd3);
		case (didx_q)
			3'd0, 3'd3: begin pl_u = 2'd0; pl_v = 2'd1; end
			3'd1, 3'd4: begin pl_u = 2'd0; pl_v = 2'd2; end
			default:    begin pl_u = 2'd1; pl_v = 2'd2; end
		endcase
	end

	// |det| against precision scaled to Q32.32
	logic [ACC_W-1:0] acc_mag;
	logic             col_pass;
	assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
	assign col_pass = (acc_mag < ACC_W'({prec_q, 16'h0000}));

	// span and room checks
	logic [T_W-1:0] span, half;
	logic [T_W:0]   tsum;
	logic           span_ok, room;
	assign span    = tmax_q - tmin_q;
	assign span_ok = ((span >> MIN_SPAN_SHIFT) != '0);
	assign room    = (level_q < LVL_W'(STACK_DEPTH));
	assign tsum    = {1'b0, tmin_q} + {1'b0, tmax_q};
	assign half    = tsum[T_W:1];

	// flatness term for axis cnt[2:1]: ctrl1 test or ctrl2 test by cnt[0]
	logic [1:0]              fl_ax;
	logic signed [FL_W-1:0]  fl_cc, fl_nn, fl_ff, fl_t;
	logic [FL_W-1:0]         fl_mag;
	logic [PREC_W+1:0]       lim3;
	logic                    fl_off;
	always_comb begin
		fl_ax  = cnt_q[2:1];
		fl_cc  = ext(cnt_q[0] ? ax_of(c2_q, fl_ax) : ax_of(c1_q, fl_ax));
		fl_nn  = ext(cnt_q[0] ? ax_of(e_q, fl_ax) : ax_of(s_q, fl_ax));
		fl_ff  = ext(cnt_q[0] ? ax_of(s_q, fl_ax) : ax_of(e_q, fl_ax));
		fl_t   = (fl_cc <<< 1) + fl_cc - (fl_nn <<< 1) - fl_ff;
		fl_mag = fl_t[FL_W-1] ? FL_W'(-fl_t) : FL_W'(fl_t);
		lim3   = {2'b00, prec_q} + {1'b0, prec_q, 1'b0};
		fl_off = (fl_mag > FL_W'(lim3));
	end

	// de Casteljau midpoints for axis cnt[3:2]
	logic [1:0]                 sp_ax;
	logic signed [COORD_W-1:0]  p0, p1c, p2c, p3c, m01, m12, m23, m012, m123, m0123;
	always_comb begin
		sp_ax = cnt_q[3:2];
		p0    = ax_of(s_q, sp_ax);
		p1c   = ax_of(c1_q, sp_ax);
		p2c   = ax_of(c2_q, sp_ax);
		p3c   = ax_of(e_q, sp_ax);
		m01   = mid(p0, p1c);
		m12   = mid(p1c, p2c);
		m23   = mid(p2c, p3c);
		m012  = mid(m01, m12);
		m123  = mid(m12, m23);
		m0123 = mid(m012, m123);
	end

	logic [LVL_W-1:0] lvl_m1;
	logic [3:0]       pop_w;
	assign lvl_m1 = level_q - 1'b1;
	assign pop_w  = cnt_q - 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_COL;
			ST_COL: begin
				if (cnt_q == 4'd3) begin
					if (!col_pass) state_d = ST_TEST;
					else if (didx_q == 3'd5) state_d = ST_CHORD;
				end
			end
			ST_TEST: begin
				if (!(span_ok && room)) state_d = ST_CHORD;
				else if (fl_off) state_d = ST_SPLIT;
				else if (cnt_q == 4'd5) state_d = ST_CHORD;
			end
			ST_SPLIT: if (cnt_q == 4'd13) state_d = ST_TEST;
			ST_CHORD: if (cnt_q == 4'd4) state_d = ST_SQRT;
			ST_SQRT: begin
				if (sq_done) state_d = (level_q == '0) ? ST_DONE : ST_POP;
			end
			ST_POP:   if (cnt_q == 4'd15) state_d = ST_TEST;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and unit control
	always_comb begin
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		mac_ctl   = '0;
		opa       = '0;
		opb       = '0;
		sq_go     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {level_q[LVL_IW-1:0], cnt_q[1:0], cnt_q[3:2]};
		mem_wdata = '0;
		mem_raddr = {lvl_m1[LVL_IW-1:0], cnt_q};
		unique case (state_q)
			ST_COL: begin
				if (cnt_q == 4'd0) begin
					mac_ctl = '{valid: 1'b1, first: 1'b1, sub: 1'b0};
					opa = diff(ax_of(e_q, pl_u), ax_of(s_q, pl_u));
					opb = diff(pl_c2 ? ax_of(c2_q, pl_v) : ax_of(c1_q, pl_v),
					           ax_of(s_q, pl_v));
				end else if (cnt_q == 4'd1) begin
					mac_ctl = '{valid: 1'b1, first: 1'b0, sub: 1'b1};
					opa = diff(ax_of(e_q, pl_v), ax_of(s_q, pl_v));
					opb = diff(pl_c2 ? ax_of(c2_q, pl_u) : ax_of(c1_q, pl_u),
					           ax_of(s_q, pl_u));
				end
			end
			ST_CHORD: begin
				if (cnt_q < 4'd3) begin
					mac_ctl = '{valid: 1'b1, first: (cnt_q == 4'd0), sub: 1'b0};
					opa = diff(ax_of(e_q, cnt_q[1:0]), ax_of(s_q, cnt_q[1:0]));
					opb = opa;
				end
				sq_go = (cnt_q == 4'd4);
			end
			ST_SPLIT: begin
				mem_we = 1'b1;
				if (cnt_q == 4'd12) begin
					mem_waddr = {level_q[LVL_IW-1:0], WORD_TMIN};
					mem_wdata = COORD_W'(half);
				end else if (cnt_q == 4'd13) begin
					mem_waddr = {level_q[LVL_IW-1:0], WORD_TMAX};
					mem_wdata = COORD_W'(tmax_q);
				end else begin
					case (cnt_q[1:0])
						2'd0:    mem_wdata = m0123;
						2'd1:    mem_wdata = m123;
						2'd2:    mem_wdata = m23;
						default: mem_wdata = p3c;
					endcase
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= '0;
			cnt_q   <= '0;
			didx_q  <= '0;
			prec_q  <= PRECISION_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wen) prec_q <= cfg_wdata;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == ST_COL && cnt_q == 4'd3) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_IDLE && start) begin
				level_q <= '0;
				didx_q  <= '0;
			end
			if (state_q == ST_COL && cnt_q == 4'd3) didx_q <= didx_q + 1'b1;
			if (state_q == ST_SPLIT && cnt_q == 4'd13) level_q <= level_q + 1'b1;
			if (state_q == ST_POP && cnt_q == 4'd15) level_q <= lvl_m1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			s_q        <= {start_z, start_y, start_x};
			c1_q       <= {ctrl1_z, ctrl1_y, ctrl1_x};
			c2_q       <= {ctrl2_z, ctrl2_y, ctrl2_x};
			e_q        <= {end_z, end_y, end_x};
			tmin_q     <= '0;
			tmax_q     <= T_W'(T_FULL_SPAN);
			len_q      <= '0;
			straight_q <= 1'b0;
		end
		if (state_q == ST_COL && cnt_q == 4'd3 && col_pass && didx_q == 3'd5) begin
			straight_q <= 1'b1;
		end
		// hold the left half in place once all four words of an axis are saved
		if (state_q == ST_SPLIT && cnt_q < 4'd12 && cnt_q[1:0] == 2'd3) begin
			c1_q[sp_ax*COORD_W +: COORD_W] <= m01;
			c2_q[sp_ax*COORD_W +: COORD_W] <= m012;
			e_q[sp_ax*COORD_W +: COORD_W]  <= m0123;
		end
		if (state_q == ST_SPLIT && cnt_q == 4'd13) tmax_q <= half;
		// restore the popped piece one word a cycle, behind the read register
		if (state_q == ST_POP && cnt_q != 4'd0) begin
			if (pop_w[1:0] == 2'd3) begin
				if (pop_w == WORD_TMIN) tmin_q <= mem_rdata[T_W-1:0];
				else if (pop_w == WORD_TMAX) tmax_q <= mem_rdata[T_W-1:0];
			end else begin
				case (pop_w[3:2])
					2'd0:    s_q[pop_w[1:0]*COORD_W +: COORD_W]  <= mem_rdata;
					2'd1:    c1_q[pop_w[1:0]*COORD_W +: COORD_W] <= mem_rdata;
					2'd2:    c2_q[pop_w[1:0]*COORD_W +: COORD_W] <= mem_rdata;
					default: e_q[pop_w[1:0]*COORD_W +: COORD_W]  <= mem_rdata;
				endcase
			end
		end
		// accumulate the chord, saturating
		if (state_q == ST_SQRT && sq_done) begin
			len_q <= add_sat(len_q, root);
		end
	end

	assign arc_length   = len_q;
	assign was_straight = straight_q;

endmodule
`default_nettype wire

@@ sv/bzl_checker.sv @@
// ----------------------------------------------------------------------------
// bzl_checker: port-level checks for the Bezier length engine
// Watches the command handshake and result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none
module bzl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [bzl_pkg::LEN_W-1:0]   arc_length,
	input logic                        was_straight
);
	import bzl_pkg::*;

	// a taken transaction always makes the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction taken but block not busy");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// busy ends only right after a result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	// a straight result is one chord of at most about 2^34
	a_straight_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_straight |-> arc_length[LEN_W-1:ROOT_W] == '0)
		else $error("straight result too long for one chord");

endmodule

bind cubic_bezier_arc_length bzl_checker u_bzl_checker (.*);
`default_nettype wire

@@ tb/tb_cubic_bezier_arc_length.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_arc_length: self-checking bench for the Bezier length engine
// Drives curves through the start/busy command port under several precision
// settings, takes each expected length from a directed row or a local
// subdivision model and checks each done strobe against the oldest one due.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_arc_length;
	import bzl_pkg::*;

	localparam int ONE = 32'h0001_0000;     // 1.0 in Q16.16
	localparam int NEG = 32'h8000_0000;
	localparam int POS = 32'h7FFF_FFFF;

	typedef logic [11:0][COORD_W-1:0] curve_t;  // s xyz, c1 xyz, c2 xyz, e xyz

	typedef struct {
		logic [LEN_W-1:0] len;
		logic             straight;
	} length_t;

	typedef struct {
		logic [PREC_W-1:0] prec;
		curve_t            pts;
		logic              typed;     // expected result given in the row
		logic [LEN_W-1:0]  len;
		logic              straight;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_wen = 1'b0;
	logic [PREC_W-1:0] cfg_wdata = '0;
	logic signed [COORD_W-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [COORD_W-1:0] ctrl1_x = '0, ctrl1_y = '0, ctrl1_z = '0;
	logic signed [COORD_W-1:0] ctrl2_x = '0, ctrl2_y = '0, ctrl2_z = '0;
	logic signed [COORD_W-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic busy, done, was_straight;
	logic [LEN_W-1:0] arc_length;

	logic [PREC_W-1:0] prec_now = PRECISION_RESET;  // mirror of the register
	length_t           lengths_due[$];
	int                n_errors = 0;

	always #6 clk = ~clk;

	cubic_bezier_arc_length dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.ctrl1_x(ctrl1_x), .ctrl1_y(ctrl1_y), .ctrl1_z(ctrl1_z),
		.ctrl2_x(ctrl2_x), .ctrl2_y(ctrl2_y), .ctrl2_z(ctrl2_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.arc_length(arc_length), .was_straight(was_straight)
	);

	// ------------------------------------------------------------------
	// Length predictor
	// ------------------------------------------------------------------
	function automatic logic [127:0] int_sqrt(logic [127:0] v);
		logic [127:0] r, c;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	// floor(sqrt(dx^2+dy^2+dz^2)) between points at word offsets sa and ea
	function automatic logic [127:0] chord_len(curve_t p, int sa, int ea);
		logic signed [127:0] d;
		logic [127:0] acc;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			d = $signed(p[ea+i]) - $signed(p[sa+i]);
			acc += d * d;
		end
		return int_sqrt(acc);
	endfunction

	function automatic logic near_chord(curve_t p, int ca, logic [PREC_W-1:0] prec);
		logic signed [127:0] ax, ay, bx, by, det, lim;
		int ia, ib;
		lim = $signed({96'd0, prec}) <<< 16;
		for (int k = 0; k < 3; k++) begin
			ia = (k == 2) ? 1 : 0;
			ib = (k == 0) ? 1 : 2;
			ax = $signed(p[9+ia]) - $signed(p[ia]);
			ay = $signed(p[9+ib]) - $signed(p[ib]);
			bx = $signed(p[ca+ia]) - $signed(p[ia]);
			by = $signed(p[ca+ib]) - $signed(p[ib]);
			det = ax * by - ay * bx;
			if (det < 0)
				det = -det;
			if (!(det < lim))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic off_thirds(curve_t p, logic [PREC_W-1:0] prec);
		longint s, c1, c2, e, d1, d2, lim;
		lim = 3 * longint'({32'd0, prec});
		for (int i = 0; i < 3; i++) begin
			s  = $signed(p[i]);
			c1 = $signed(p[3+i]);
			c2 = $signed(p[6+i]);
			e  = $signed(p[9+i]);
			d1 = 3 * c1 - 2 * s - e;
			d2 = 3 * c2 - s - 2 * e;
			if (d1 < 0) d1 = -d1;
			if (d2 < 0) d2 = -d2;
			if (d1 > lim || d2 > lim)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [COORD_W-1:0] halve(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		longint t;
		t = (longint'($signed(a)) + longint'($signed(b))) >>> 1;
		return t[COORD_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] acc, logic [127:0] v);
		logic [127:0] s;
		s = {88'd0, acc} + v;
		return (s > {88'd0, {LEN_W{1'b1}}}) ? {LEN_W{1'b1}} : s[LEN_W-1:0];
	endfunction

	function automatic length_t predict_length(curve_t in, logic [PREC_W-1:0] prec);
		length_t res;
		curve_t cur, saved [STACK_DEPTH_DEF];
		logic [31:0] span_lo [STACK_DEPTH_DEF], span_hi [STACK_DEPTH_DEF];
		logic [31:0] tlo, thi, half;
		logic [COORD_W-1:0] p1, bc, p5, p2, p4, p3;
		int level;
		res.len = '0;
		res.straight = 1'b0;
		if (near_chord(in, 3, prec) && near_chord(in, 6, prec)) begin
			res.len = sat_add('0, chord_len(in, 0, 9));
			res.straight = 1'b1;
			return res;
		end
		cur = in;
		tlo = 0;
		thi = T_FULL_SPAN_DEF;
		level = 0;
		forever begin
			if (((thi - tlo) >> MIN_SPAN_SHIFT_DEF) != 0 && level < STACK_DEPTH_DEF &&
			    off_thirds(cur, prec)) begin
				// split: keep the left half, push the right half
				half = (tlo + thi) >> 1;
				for (int i = 0; i < 3; i++) begin
					p1 = halve(cur[i], cur[3+i]);
					bc = halve(cur[3+i], cur[6+i]);
					p5 = halve(cur[6+i], cur[9+i]);
					p2 = halve(p1, bc);
					p4 = halve(bc, p5);
					p3 = halve(p2, p4);
					saved[level][i]   = p3;
					saved[level][3+i] = p4;
					saved[level][6+i] = p5;
					saved[level][9+i] = cur[9+i];
					cur[3+i] = p1;
					cur[6+i] = p2;
					cur[9+i] = p3;
				end
				span_lo[level] = half;
				span_hi[level] = thi;
				level++;
				thi = half;
			end else begin
				res.len = sat_add(res.len, chord_len(cur, 0, 9));
				if (level == 0)
					break;
				level--;
				cur = saved[level];
				tlo = span_lo[level];
				thi = span_hi[level];
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic curve_t make_curve(int sx, int sy, int sz, int ax, int ay, int az,
	                                      int bx, int by, int bz, int ex, int ey, int ez);
		curve_t c;
		c = {ez, ey, ex, bz, by, bx, az, ay, ax, sz, sy, sx};
		return c;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $realtime, what);
		n_errors++;
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold start until the curve is taken and busy falls; idle_gap may drop it
	task automatic send_curve(curve_t p, length_t want);
		start_x <= p[0];  start_y <= p[1];  start_z <= p[2];
		ctrl1_x <= p[3];  ctrl1_y <= p[4];  ctrl1_z <= p[5];
		ctrl2_x <= p[6];  ctrl2_y <= p[7];  ctrl2_z <= p[8];
		end_x   <= p[9];  end_y   <= p[10]; end_z   <= p[11];
		start   <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		lengths_due.push_back(want);
		idle_gap();
	endtask

	// write precision only with the engine idle and nothing outstanding
	task automatic set_precision(logic [PREC_W-1:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (lengths_due.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		prec_now  = v;
	endtask

	function automatic curve_t random_curve(int mode);
		curve_t c;
		int s, d;
		for (int i = 0; i < 3; i++) begin
			case (mode)
				0: begin  // evenly spaced points on a line: exactly flat
					s = $signed($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
					d = $signed($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
					c[i] = s; c[3+i] = s + d; c[6+i] = s + 2 * d; c[9+i] = s + 3 * d;
				end
				1: begin  // small random curve
					for (int k = 0; k < 4; k++)
						c[3*k+i] = $signed($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
				end
				default: begin  // any coordinate at all
					for (int k = 0; k < 4; k++)
						c[3*k+i] = $urandom;
				end
			endcase
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: every done strobe is one transaction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		length_t want;
		if (arst_n && done) begin
			if (lengths_due.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = lengths_due.pop_front();
				if (arc_length !== want.len)
					report_mismatch($sformatf("arc_length %0h, expected %0h",
						arc_length, want.len));
				if (was_straight !== want.straight)
					report_mismatch($sformatf("was_straight %0b, expected %0b",
						was_straight, want.straight));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		plan_row_t plan [9];
		length_t want;
		logic [PREC_W-1:0] phase_prec [6];
		int mode;

		// directed rows: straight lines, a curve, extremes, zero tolerance
		plan[0] = '{PRECISION_RESET, make_curve(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1, 40'd0, 1};
		plan[1] = '{PRECISION_RESET,
			make_curve(0,0,0, ONE,0,0, 2*ONE,0,0, 3*ONE,0,0), 1, 40'd196608, 1};
		plan[2] = '{PRECISION_RESET,
			make_curve(0,0,0, 3*ONE,4*ONE,0, 3*ONE,4*ONE,0, 6*ONE,8*ONE,0), 1, 40'd655360, 1};
		plan[3] = '{PRECISION_RESET,
			make_curve(0,0,0, 0,4*ONE,0, 4*ONE,4*ONE,0, 4*ONE,0,0), 0, '0, 0};
		plan[4] = '{PRECISION_RESET,
			make_curve(NEG,NEG,NEG, NEG,NEG,NEG, POS,POS,POS, POS,POS,POS), 0, '0, 0};
		plan[5] = '{32'hFFFF_FFFF,
			make_curve(NEG,NEG,NEG, POS,POS,POS, NEG,NEG,NEG, POS,POS,POS), 0, '0, 0};
		plan[6] = '{32'hFFFF_FFFF, make_curve(32'h5555_5555, 32'hAAAA_AAAA, 0,
			32'hAAAA_AAAA, 32'h5555_5555, -1, -1, 0, 32'h5555_5555,
			0, -1, 32'hAAAA_AAAA), 0, '0, 0};
		// zero tolerance: never straight, only exact thirds count as flat
		plan[7] = '{32'd0, make_curve(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1, 40'd0, 0};
		plan[8] = '{32'd0, make_curve(0,0,0, 3,0,0, 6,0,0, 9,0,0), 1, 40'd9, 0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].prec != prec_now || r == 0)
				set_precision(plan[r].prec);
			if (plan[r].typed) begin
				want.len = plan[r].len;
				want.straight = plan[r].straight;
			end else begin
				want = predict_length(plan[r].pts, prec_now);
			end
			send_curve(plan[r].pts, want);
		end

		// random phases; full-range curves only with a loose tolerance to keep
		// the number of pieces per curve small
		phase_prec = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1 << 20,
			$urandom_range(1 << 14, 1 << 18), 32'd3 << 15};
		foreach (phase_prec[ph]) begin
			set_precision(phase_prec[ph]);
			for (int n = 0; n < 100; n++) begin
				if (prec_now == 0)
					mode = 0;
				else if (prec_now == 32'hFFFF_FFFF)
					mode = $urandom_range(0, 2);
				else
					mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
				begin
					curve_t c;
					c = random_curve(mode);
					send_curve(c, predict_length(c, prec_now));
				end
			end
		end

		// drain, then allow a little for anything unexpected to appear
		start <= 1'b0;
		@(posedge clk);
		while (lengths_due.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#(64'd400_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule
